/* rtl/integer_alu_with_power_assert.svh */
// Assertion macros for the integer ALU with power.
// Used by the top level; relies on clk and rst in the including scope.
`ifndef INTEGER_ALU_WITH_POWER_ASSERT_SVH
`define INTEGER_ALU_WITH_POWER_ASSERT_SVH

// Same-cycle implication
`define IALU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define IALU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ialu_pkg.sv */
// Shared types and constants for the integer ALU with power.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ialu_pkg;

  localparam int DATA_WIDTH_DEF = 64;

  localparam int FUNC_W      = 3;
  localparam int OPND_W      = 64;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 64;

  localparam int FUNC_LSB = 0;
  localparam int LHS_LSB  = 3;
  localparam int RHS_LSB  = 67;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_REM = 3'd4,
    FUNC_POW = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_DIV0    = 2'd1,
    ST_OVF     = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_WAIT,
    S_DIV_WAIT,
    S_POW_STEP,
    S_POW_ACC,
    S_POW_SHIFT,
    S_POW_SQ,
    S_DONE
  } state_t;

endpackage

/* rtl/ialu_mul.sv */
// Shared unsigned multiplier: full product from four half-width partial
// products, formed in turn and accumulated. Depends on ialu_pkg.
`timescale 1ns / 1ps

module ialu_mul #(
  parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [DATA_WIDTH-1:0]                a,
  input  logic [DATA_WIDTH-1:0]                b,
  output logic                                 done,
  output logic [4*((DATA_WIDTH+1)/2)-1:0]      prod
);

  localparam int H  = (DATA_WIDTH + 1) / 2;
  localparam int PW = 4 * H;

  logic          busy;
  logic [2:0]    cnt;
  logic [2*H-1:0] a_r;
  logic [2*H-1:0] b_r;
  logic [2*H-1:0] pp;
  logic [1:0]    pp_pos;
  logic [PW-1:0] acc;
  logic [H-1:0]  a_half;
  logic [H-1:0]  b_half;
  logic [PW-1:0] pp_shifted;

  assign a_half = cnt[1] ? a_r[2*H-1:H] : a_r[H-1:0];
  assign b_half = cnt[0] ? b_r[2*H-1:H] : b_r[H-1:0];
  assign prod   = acc;

  always_comb begin
    case (pp_pos)
      2'd0:    pp_shifted = PW'(pp);
      2'd1:    pp_shifted = PW'(pp) << H;
      2'd2:    pp_shifted = PW'(pp) << (2 * H);
      default: pp_shifted = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= (2*H)'(a);
      b_r <= (2*H)'(b);
      acc <= '0;
    end else if (busy) begin
      pp     <= a_half * b_half;
      pp_pos <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
      if (cnt != 3'd0) begin
        acc <= acc + pp_shifted;
      end
    end
  end

endmodule

/* rtl/ialu_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ialu_pkg.
`timescale 1ns / 1ps

module ialu_div #(
  parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic [DATA_WIDTH-1:0] remainder
);

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  d_r;
  logic [W+1:0]  diff;

  assign diff      = {1'b0, rem, quo[W-1]} - {2'b00, d_r};
  assign quotient  = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      d_r <= divisor;
    end else if (busy) begin
      if (!diff[W+1]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/integer_alu_with_power.sv */
// Top level of the integer ALU with power: sequencer and result register.
// Depends on ialu_pkg, ialu_mul, ialu_div and the assertion header.
`timescale 1ns / 1ps
`include "integer_alu_with_power_assert.svh"

// Signed DATA_WIDTH-bit ALU: add, sub, mul, div, rem and exact power.
// Input channel s_*: one request per handshake, s_tdata carries func, lhs
// and rhs; only the low DATA_WIDTH bits of lhs and rhs are used.
// Output channel m_*: one result per request, m_tdata is the result
// sign-extended to 64 bits, m_tuser the status code.
// s_tready is high only while the sequencer is idle; one request is in
// flight at a time. add, sub, an invalid opcode, a zero divisor and a
// trivial power go straight to the done state; mul forms four partial
// products on one half-width multiplier; div and rem take one quotient
// bit per cycle; pow takes one exponent bit per round, each round up to
// two products on the shared multiplier.
// A result waits in the output register while m_tready is low; the next
// request is still accepted and is held once finished until the output
// register frees. Reset clears the sequencer and drops any pending output.

module integer_alu_with_power #(
  parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ialu_pkg::IN_TDATA_W-1:0]    s_tdata,  // func[2:0], lhs[66:3], rhs[130:67]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ialu_pkg::OUT_TDATA_W-1:0]   m_tdata,  // result[63:0]
  output logic [ialu_pkg::STATUS_W-1:0]      m_tuser   // status[1:0]
);

  localparam int W  = DATA_WIDTH;
  localparam int H  = (W + 1) / 2;
  localparam int PW = 4 * H;

  localparam logic [W-1:0] W_MIN  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] W_MAX  = ~W_MIN;
  localparam logic [W-1:0] W_ONE  = W'(1);
  localparam logic [W-1:0] W_ONES = '1;

  ialu_pkg::state_t  state, state_next;
  ialu_pkg::func_t   func_r, func_next;
  ialu_pkg::status_t st_r, st_next;

  logic [W-1:0] a_r, a_next;
  logic [W-1:0] b_r, b_next;
  logic [W-1:0] res_r, res_next;
  logic [W-1:0] base, base_next;
  logic [W-1:0] acc, acc_next;
  logic [W-1:0] expn, expn_next;
  logic [W-1:0] lim, lim_next;
  logic         neg, neg_next;
  logic         base_over, base_over_next;

  logic                        m_tvalid_next;
  logic [ialu_pkg::OUT_TDATA_W-1:0] m_tdata_next;
  logic [ialu_pkg::STATUS_W-1:0]    m_tuser_next;

  logic [ialu_pkg::FUNC_W-1:0] in_func;
  logic [W-1:0] in_a;
  logic [W-1:0] in_b;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic         in_neg;

  logic          mul_start;
  logic [W-1:0]  mul_a;
  logic [W-1:0]  mul_b;
  logic          mul_done;
  logic [PW-1:0] mul_prod;

  logic          div_start;
  logic          div_done;
  logic [W-1:0]  div_q;
  logic [W-1:0]  div_r;

  assign in_func  = s_tdata[ialu_pkg::FUNC_LSB +: ialu_pkg::FUNC_W];
  assign in_a     = s_tdata[ialu_pkg::LHS_LSB +: W];
  assign in_b     = s_tdata[ialu_pkg::RHS_LSB +: W];
  assign mag_a    = in_a[W-1] ? -in_a : in_a;
  assign mag_b    = in_b[W-1] ? -in_b : in_b;
  assign in_neg   = in_a[W-1] & in_b[0];
  assign s_tready = (state == ialu_pkg::S_IDLE);

  ialu_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ialu_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag_a),
    .divisor   (mag_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ialu_pkg::S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_next;
    st_r      <= st_next;
    a_r       <= a_next;
    b_r       <= b_next;
    res_r     <= res_next;
    base      <= base_next;
    acc       <= acc_next;
    expn      <= expn_next;
    lim       <= lim_next;
    neg       <= neg_next;
    base_over <= base_over_next;
    m_tdata   <= m_tdata_next;
    m_tuser   <= m_tuser_next;
  end

  always_comb begin
    state_next     = state;
    func_next      = func_r;
    st_next        = st_r;
    a_next         = a_r;
    b_next         = b_r;
    res_next       = res_r;
    base_next      = base;
    acc_next       = acc;
    expn_next      = expn;
    lim_next       = lim;
    neg_next       = neg;
    base_over_next = base_over;
    m_tvalid_next  = m_tvalid && !m_tready;
    m_tdata_next   = m_tdata;
    m_tuser_next   = m_tuser;
    mul_start      = 1'b0;
    mul_a          = acc;
    mul_b          = base;
    div_start      = 1'b0;

    unique case (state)
      ialu_pkg::S_IDLE: begin
        if (s_tvalid) begin
          func_next  = ialu_pkg::func_t'(in_func);
          a_next     = in_a;
          b_next     = in_b;
          st_next    = ialu_pkg::ST_OK;
          res_next   = '0;
          state_next = ialu_pkg::S_DONE;
          case (in_func) inside
            ialu_pkg::FUNC_ADD: res_next = in_a + in_b;
            ialu_pkg::FUNC_SUB: res_next = in_a - in_b;
            ialu_pkg::FUNC_MUL: begin
              mul_start  = 1'b1;
              mul_a      = in_a;
              mul_b      = in_b;
              state_next = ialu_pkg::S_MUL_WAIT;
            end
            ialu_pkg::FUNC_DIV, ialu_pkg::FUNC_REM: begin
              if (in_b == '0) begin
                st_next = ialu_pkg::ST_DIV0;
              end else begin
                div_start  = 1'b1;
                state_next = ialu_pkg::S_DIV_WAIT;
              end
            end
            ialu_pkg::FUNC_POW: begin
              if (in_b[W-1]) begin
                if (in_a == W_ONE) begin
                  res_next = W_ONE;
                end else if (in_a == W_ONES) begin
                  res_next = in_b[0] ? W_ONES : W_ONE;
                end else if (in_a == '0) begin
                  st_next = ialu_pkg::ST_DIV0;
                end
              end else if (in_a == '0) begin
                res_next = (in_b == '0) ? W_ONE : '0;
              end else begin
                base_next      = mag_a;
                neg_next       = in_neg;
                lim_next       = in_neg ? W_MIN : W_MAX;
                expn_next      = in_b;
                acc_next       = W_ONE;
                base_over_next = 1'b0;
                state_next     = ialu_pkg::S_POW_STEP;
              end
            end
            default: st_next = ialu_pkg::ST_INVALID;
          endcase
        end
      end

      ialu_pkg::S_MUL_WAIT: begin
        if (mul_done) begin
          res_next   = mul_prod[W-1:0];
          state_next = ialu_pkg::S_DONE;
        end
      end

      ialu_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          state_next = ialu_pkg::S_DONE;
          if (func_r == ialu_pkg::FUNC_DIV) begin
            res_next = (a_r[W-1] != b_r[W-1]) ? -div_q : div_q;
            if (a_r == W_MIN && b_r == W_ONES) begin
              st_next = ialu_pkg::ST_OVF;
            end
          end else begin
            res_next = a_r[W-1] ? -div_r : div_r;
          end
        end
      end

      ialu_pkg::S_POW_STEP: begin
        if (expn == '0) begin
          res_next   = neg ? -acc : acc;
          state_next = ialu_pkg::S_DONE;
        end else if (expn[0]) begin
          if (base_over || base > lim) begin
            res_next   = neg ? W_MIN : W_MAX;
            st_next    = ialu_pkg::ST_OVF;
            state_next = ialu_pkg::S_DONE;
          end else begin
            mul_start  = 1'b1;
            state_next = ialu_pkg::S_POW_ACC;
          end
        end else begin
          state_next = ialu_pkg::S_POW_SHIFT;
        end
      end

      ialu_pkg::S_POW_ACC: begin
        if (mul_done) begin
          if (mul_prod > PW'(lim)) begin
            res_next   = neg ? W_MIN : W_MAX;
            st_next    = ialu_pkg::ST_OVF;
            state_next = ialu_pkg::S_DONE;
          end else begin
            acc_next   = mul_prod[W-1:0];
            state_next = ialu_pkg::S_POW_SHIFT;
          end
        end
      end

      ialu_pkg::S_POW_SHIFT: begin
        expn_next = expn >> 1;
        if ((expn >> 1) != '0 && !base_over) begin
          mul_start  = 1'b1;
          mul_a      = base;
          state_next = ialu_pkg::S_POW_SQ;
        end else begin
          state_next = ialu_pkg::S_POW_STEP;
        end
      end

      ialu_pkg::S_POW_SQ: begin
        mul_a = base;
        if (mul_done) begin
          if (mul_prod > PW'(lim)) begin
            base_over_next = 1'b1;
          end else begin
            base_next = mul_prod[W-1:0];
          end
          state_next = ialu_pkg::S_POW_STEP;
        end
      end

      ialu_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = ialu_pkg::OUT_TDATA_W'($signed(res_r));
          m_tuser_next  = st_r;
          state_next    = ialu_pkg::S_IDLE;
        end
      end

      default: state_next = ialu_pkg::S_IDLE;
    endcase
  end

  `IALU_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
  `IALU_ASSERT_SAME(a_invalid_zero, m_tvalid && m_tuser == ialu_pkg::ST_INVALID, m_tdata == '0, "invalid op result not zero")
  `IALU_ASSERT_SAME(a_div0_zero, m_tvalid && m_tuser == ialu_pkg::ST_DIV0, m_tdata == '0, "divide by zero result not zero")

endmodule

/* test/integer_alu_with_power_tb.sv */
// Self-checking testbench for integer_alu_with_power: a predictor built from typed requests
// checks each result and status, under random idling and one long output hold-off.
// Depends on ialu_pkg and the integer_alu_with_power top level.
`timescale 1ns / 1ps

module integer_alu_with_power_tb;

  localparam logic [ialu_pkg::FUNC_W-1:0] FUNC_BAD6 = 3'd6;
  localparam logic [ialu_pkg::FUNC_W-1:0] FUNC_BAD7 = 3'd7;
  localparam logic [63:0] MAXV = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;
  localparam logic [63:0] NEG1 = 64'hffff_ffff_ffff_ffff;
  localparam int RANDOM_ITEMS = 1430;
  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_LEN     = 400;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [ialu_pkg::FUNC_W-1:0] func;
    logic [63:0]                 lhs;
    logic [63:0]                 rhs;
  } alu_req_t;

  typedef struct packed {
    logic [63:0]       result;
    ialu_pkg::status_t status;
  } alu_resp_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [ialu_pkg::IN_TDATA_W-1:0]  s_tdata = '0;   // func[2:0], lhs[66:3], rhs[130:67]
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [ialu_pkg::OUT_TDATA_W-1:0] m_tdata;        // result[63:0]
  logic [ialu_pkg::STATUS_W-1:0]    m_tuser;        // status[1:0]

  alu_req_t  pending_q[$];
  alu_resp_t expected_q[$];
  alu_req_t  cur_req, next_req;
  alu_resp_t want;
  int        send_gap = 0, rcv_stall = 0, hold_cnt = 0, rdy_draw = 0;
  int        sent_cnt = 0, rcv_cnt = 0, quiet_cnt = 0, errors = 0, n;

  integer_alu_with_power dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic alu_resp_t alu_predict(alu_req_t r);
    alu_resp_t    o;
    logic [63:0]  a, b, ua, ub, q, rm, base, e, acc, lim;
    logic [127:0] prod;
    logic         neg, sq_over, done;
    o.result = '0;
    o.status = ialu_pkg::ST_OK;
    a = r.lhs;
    b = r.rhs;
    case (r.func) inside
      ialu_pkg::FUNC_ADD: o.result = a + b;
      ialu_pkg::FUNC_SUB: o.result = a - b;
      ialu_pkg::FUNC_MUL: o.result = a * b;
      ialu_pkg::FUNC_DIV, ialu_pkg::FUNC_REM: begin
        if (b == 64'd0) begin
          o.status = ialu_pkg::ST_DIV0;
        end else begin
          ua = a[63] ? -a : a;
          ub = b[63] ? -b : b;
          q  = ua / ub;
          rm = ua % ub;
          if (r.func == ialu_pkg::FUNC_DIV) begin
            o.result = (a[63] ^ b[63]) ? -q : q;
            if (a == MINV && b == NEG1) o.status = ialu_pkg::ST_OVF;
          end else begin
            o.result = a[63] ? -rm : rm;
          end
        end
      end
      ialu_pkg::FUNC_POW: begin
        if (b[63]) begin
          if (a == 64'd1) o.result = 64'd1;
          else if (a == NEG1) o.result = b[0] ? NEG1 : 64'd1;
          else if (a == 64'd0) o.status = ialu_pkg::ST_DIV0;
        end else if (a == 64'd0) begin
          o.result = (b == 64'd0) ? 64'd1 : 64'd0;
        end else begin
          base    = a[63] ? -a : a;
          neg     = a[63] & b[0];
          lim     = MAXV + {63'd0, neg};
          e       = b;
          acc     = 64'd1;
          sq_over = 1'b0;
          done    = 1'b0;
          while (e != 64'd0 && !done) begin
            if (e[0]) begin
              prod = {64'd0, acc} * {64'd0, base};
              if (sq_over || prod > {64'd0, lim}) begin
                o.status = ialu_pkg::ST_OVF;
                o.result = neg ? MINV : MAXV;
                done     = 1'b1;
              end else begin
                acc = prod[63:0];
              end
            end
            e = e >> 1;
            if (!done && e != 64'd0 && !sq_over) begin
              prod = {64'd0, base} * {64'd0, base};
              if (prod > {64'd0, lim}) sq_over = 1'b1;
              else base = prod[63:0];
            end
          end
          if (!done) o.result = neg ? -acc : acc;
        end
      end
      default: o.status = ialu_pkg::ST_INVALID;
    endcase
    return o;
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    case ($urandom_range(0, 3)) inside
      0, 1: v = {$urandom, $urandom};
      2: v = 64'($urandom_range(0, 40)) - 64'd20;
      default: begin
        case ($urandom_range(0, 4))
          0: v = MINV;
          1: v = MAXV;
          2: v = 64'd0;
          3: v = 64'd1;
          default: v = NEG1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic add_req(logic [ialu_pkg::FUNC_W-1:0] f, logic [63:0] l, logic [63:0] r);
    alu_req_t t;
    t.func = f;
    t.lhs  = l;
    t.rhs  = r;
    pending_q.insert(pending_q.size(), t);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_q.insert(expected_q.size(), alu_predict(cur_req));
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0 || pending_q.size() == 0) begin
          s_tvalid <= 1'b0;
          if (send_gap != 0) send_gap <= send_gap - 1;
        end else begin
          next_req = pending_q.pop_front();
          cur_req  <= next_req;
          s_tdata  <= {5'd0, next_req.rhs, next_req.lhs, next_req.func};
          s_tvalid <= 1'b1;
          send_gap <= (sent_cnt % 300 < 60) ? 0 : $urandom_range(0, 3);
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      rcv_stall <= 0;
      hold_cnt  <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h status %0d", $time, m_tdata, m_tuser);
        end else begin
          want = expected_q.pop_front();
          if (m_tdata !== want.result) begin
            errors++;
            $display("%0t: result mismatch expected %h actual %h", $time, want.result, m_tdata);
          end
          if (m_tuser !== want.status) begin
            errors++;
            $display("%0t: status mismatch expected %0d actual %0d", $time, want.status,
                     m_tuser);
          end
        end
        rcv_cnt <= rcv_cnt + 1;
      end
      if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready && rcv_cnt == HOLD_AT) begin
        // hold off the output so the block backs up onto its input
        hold_cnt <= HOLD_LEN;
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        rdy_draw = (rcv_cnt % 250 < 50) ? 0 : $urandom_range(0, 3);
        rcv_stall <= rdy_draw;
        m_tready  <= (rdy_draw == 0);
      end else if (rcv_stall != 0) begin
        rcv_stall <= rcv_stall - 1;
        m_tready  <= (rcv_stall == 1);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt == QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  initial begin
    add_req(ialu_pkg::FUNC_ADD, MAXV, 64'd1);
    add_req(ialu_pkg::FUNC_SUB, MINV, 64'd1);
    add_req(ialu_pkg::FUNC_MUL, MINV, NEG1);
    add_req(ialu_pkg::FUNC_MUL, MAXV, MAXV);
    add_req(ialu_pkg::FUNC_DIV, 64'd7, 64'd0);
    add_req(ialu_pkg::FUNC_REM, MINV, 64'd0);
    add_req(ialu_pkg::FUNC_DIV, MINV, NEG1);
    add_req(ialu_pkg::FUNC_REM, MINV, NEG1);
    add_req(ialu_pkg::FUNC_DIV, -64'd7, 64'd2);
    add_req(ialu_pkg::FUNC_REM, -64'd7, 64'd2);
    add_req(ialu_pkg::FUNC_REM, 64'd7, -64'd2);
    add_req(ialu_pkg::FUNC_DIV, MAXV, MINV);
    add_req(ialu_pkg::FUNC_POW, 64'd0, 64'd0);
    add_req(ialu_pkg::FUNC_POW, 64'd0, NEG1);
    add_req(ialu_pkg::FUNC_POW, 64'd1, -64'd5);
    add_req(ialu_pkg::FUNC_POW, NEG1, -64'd3);
    add_req(ialu_pkg::FUNC_POW, NEG1, -64'd4);
    add_req(ialu_pkg::FUNC_POW, 64'd2, NEG1);
    add_req(ialu_pkg::FUNC_POW, 64'd2, 64'd62);
    add_req(ialu_pkg::FUNC_POW, 64'd2, 64'd63);
    add_req(ialu_pkg::FUNC_POW, -64'd2, 64'd63);
    add_req(ialu_pkg::FUNC_POW, -64'd2, 64'd65);
    add_req(ialu_pkg::FUNC_POW, 64'd3, 64'd40);
    add_req(ialu_pkg::FUNC_POW, NEG1, MAXV);
    add_req(ialu_pkg::FUNC_POW, 64'd1, MAXV);
    add_req(FUNC_BAD6, MAXV, MINV);
    add_req(FUNC_BAD7, NEG1, NEG1);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      n = $urandom_range(0, 7);
      if (n == ialu_pkg::FUNC_POW) begin
        case ($urandom_range(0, 9)) inside
          0: add_req(ialu_pkg::FUNC_POW, 64'($urandom_range(0, 16)) - 64'd8,
                     {1'b1, 31'($urandom), $urandom});
          1, 2: add_req(ialu_pkg::FUNC_POW, rand_operand(), rand_operand());
          default: add_req(ialu_pkg::FUNC_POW, 64'($urandom_range(0, 16)) - 64'd8,
                           64'($urandom_range(0, 70)));
        endcase
      end else begin
        add_req(n[ialu_pkg::FUNC_W-1:0], rand_operand(), rand_operand());
      end
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ialu_pkg.sv
rtl/ialu_mul.sv
rtl/ialu_div.sv
rtl/integer_alu_with_power.sv
test/integer_alu_with_power_tb.sv
